// ===== rtl/sas_pkg.sv =====
// Shared types and constants of the sprite animation sequencer.
// Used by sas_ctrl, sas_datapath and sprite_animation_sequencer; no dependencies.
package sas_pkg;

   // frame table geometry
   localparam int MAX_FRAMES = 64;
   localparam int FRAME_W    = $clog2(MAX_FRAMES);
   localparam int FCOUNT_W   = 7;
   localparam int RATE_UNIT  = 100;

   // datapath widths
   localparam int RATE_W  = 9;
   localparam int ACC_W   = 10;
   localparam int CNT_W   = 17;
   localparam int TIME_W  = 16;
   localparam int CELL_W  = 10;
   localparam int COORD_W = 16;
   localparam int POS_W   = 17;

   // channel widths
   localparam int KIND_W     = 3;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 9;

   // request kinds
   localparam logic [KIND_W-1:0] REQ_TICK   = 3'd0;
   localparam logic [KIND_W-1:0] REQ_WRITE  = 3'd1;
   localparam logic [KIND_W-1:0] REQ_START  = 3'd2;
   localparam logic [KIND_W-1:0] REQ_SETPOS = 3'd3;
   localparam logic [KIND_W-1:0] REQ_CLEAR  = 3'd4;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_PLAY_MODE   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_COUNT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOOP_START  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RATE        = 2'd3;

   // input transaction payload, last declared field in the lowest bits
   typedef struct packed {
      logic [5:0]                pad;
      logic                      new_vflip;
      logic                      new_hflip;
      logic signed [COORD_W-1:0] new_y;
      logic signed [COORD_W-1:0] new_x;
      logic signed [COORD_W-1:0] entry_dy;
      logic signed [COORD_W-1:0] entry_dx;
      logic [CELL_W-1:0]         entry_cell;
      logic [TIME_W-1:0]         entry_time;
      logic [FRAME_W-1:0]        entry_index;
   } req_item_type;

   // result transaction payload, last declared field in the lowest bits
   typedef struct packed {
      logic [1:0]              pad;
      logic                    is_stopped;
      logic                    is_active;
      logic [FRAME_W-1:0]      current_frame;
      logic                    shown_vflip;
      logic                    shown_hflip;
      logic signed [POS_W-1:0] shown_y;
      logic signed [POS_W-1:0] shown_x;
      logic [CELL_W-1:0]       shown_cell;
   } rsp_item_type;

   // one frame table entry
   typedef struct packed {
      logic [TIME_W-1:0]         hold_time;
      logic [CELL_W-1:0]         cell_id;
      logic signed [COORD_W-1:0] dx;
      logic signed [COORD_W-1:0] dy;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic step;
      logic load_cnt;
      logic rd_en;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              active;
      logic              accum_pos;
      logic              step_wrap;
      logic              rsp_free;
   } status_type;

endpackage

// ===== rtl/sas_datapath.sv =====
// Datapath of the sprite animation sequencer: frame table memory, playback state,
// configuration registers and the result register. Depends on sas_pkg.
module sas_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [sas_pkg::KIND_W-1:0]     req_kind,
   input  sas_pkg::req_item_type          req_item,
   input  logic                           csr_we,
   input  logic [sas_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [sas_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output sas_pkg::rsp_item_type          rsp_item,
   input  sas_pkg::cmd_type               cmd,
   output sas_pkg::status_type            stat
);
   import sas_pkg::*;

   // frame table
   entry_type mem [MAX_FRAMES];
   entry_type rd_data_ff;

   // captured request
   logic [KIND_W-1:0] kind_ff;
   req_item_type      item_ff;

   // configuration
   logic                play_mode_ff, play_mode_in;
   logic [FCOUNT_W-1:0] frame_count_ff, frame_count_in;
   logic [FRAME_W-1:0]  loop_start_ff, loop_start_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;

   // playback state
   logic [FRAME_W-1:0]      pos_ff, pos_in;
   logic signed [ACC_W-1:0] accum_ff, accum_in;
   logic signed [CNT_W-1:0] cnt_ff, cnt_in;
   logic                    active_ff, active_in;
   logic                    stop_ff, stop_in;
   logic signed [COORD_W-1:0] base_x_ff, base_x_in;
   logic signed [COORD_W-1:0] base_y_ff, base_y_in;
   logic                    hflip_ff, hflip_in;
   logic                    vflip_ff, vflip_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff;

   // step helpers
   logic signed [CNT_W-1:0] cnt_dec;
   logic                    wrap;
   logic [FCOUNT_W-1:0]     count_eff;
   logic [FCOUNT_W-1:0]     pos_next;
   logic                    is_last;
   logic [RATE_W-1:0]       rate_eff;
   logic signed [POS_W-1:0] x_sum;
   logic signed [POS_W-1:0] y_sum;
   logic                    rsp_free;

   assign cnt_dec   = cnt_ff - CNT_W'(1);
   assign wrap      = cnt_dec[CNT_W-1] || (cnt_dec == '0);
   assign count_eff = (frame_count_ff > FCOUNT_W'(MAX_FRAMES)) ?
                      FCOUNT_W'(MAX_FRAMES) : frame_count_ff;
   assign pos_next  = FCOUNT_W'(pos_ff) + FCOUNT_W'(1);
   assign is_last   = (pos_next >= count_eff);
   assign rate_eff  = stop_ff ? '0 : rate_ff;
   assign x_sum     = POS_W'(base_x_ff) + POS_W'(rd_data_ff.dx);
   assign y_sum     = POS_W'(base_y_ff) + POS_W'(rd_data_ff.dy);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   // next state of configuration and playback
   always_comb begin
      play_mode_in   = play_mode_ff;
      frame_count_in = frame_count_ff;
      loop_start_in  = loop_start_ff;
      rate_in        = rate_ff;
      pos_in         = pos_ff;
      accum_in       = accum_ff;
      cnt_in         = cnt_ff;
      active_in      = active_ff;
      stop_in        = stop_ff;
      base_x_in      = base_x_ff;
      base_y_in      = base_y_ff;
      hflip_in       = hflip_ff;
      vflip_in       = vflip_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      // configuration writes
      if (csr_we) begin
         case (csr_addr)
            CSR_PLAY_MODE:   play_mode_in   = csr_wdata[0];
            CSR_FRAME_COUNT: frame_count_in = csr_wdata[FCOUNT_W-1:0];
            CSR_LOOP_START:  loop_start_in  = csr_wdata[FRAME_W-1:0];
            CSR_RATE:        rate_in        = csr_wdata[RATE_W-1:0];
            default:         rate_in        = rate_ff;
         endcase
      end

      // request action
      if (cmd.exec) begin
         case (kind_ff)
            REQ_TICK: begin
               if (active_ff) accum_in = accum_ff - ACC_W'(rate_eff);
            end
            REQ_START, REQ_CLEAR: begin
               pos_in    = '0;
               accum_in  = '0;
               stop_in   = 1'b0;
               rate_in   = RATE_W'(RATE_UNIT);
               active_in = (kind_ff == REQ_START);
            end
            REQ_SETPOS: begin
               base_x_in = item_ff.new_x;
               base_y_in = item_ff.new_y;
               hflip_in  = item_ff.new_hflip;
               vflip_in  = item_ff.new_vflip;
            end
            default: begin
               pos_in = pos_ff;
            end
         endcase
      end

      // one frame step: refill accumulator, count down, on expiry advance, loop or stop
      if (cmd.step) begin
         accum_in = accum_ff + ACC_W'(RATE_UNIT);
         cnt_in   = cnt_dec;
         if (wrap) begin
            if (!is_last)          pos_in  = pos_next[FRAME_W-1:0];
            else if (play_mode_ff) pos_in  = loop_start_ff;
            else                   stop_in = 1'b1;
         end
      end

      // reload countdown from the entry just read
      if (cmd.load_cnt) cnt_in = CNT_W'(rd_data_ff.hold_time);

      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         play_mode_ff   <= 1'b0;
         frame_count_ff <= FCOUNT_W'(1);
         loop_start_ff  <= '0;
         rate_ff        <= RATE_W'(RATE_UNIT);
         pos_ff         <= '0;
         accum_ff       <= '0;
         cnt_ff         <= '0;
         active_ff      <= 1'b0;
         stop_ff        <= 1'b0;
         base_x_ff      <= '0;
         base_y_ff      <= '0;
         hflip_ff       <= 1'b0;
         vflip_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         play_mode_ff   <= play_mode_in;
         frame_count_ff <= frame_count_in;
         loop_start_ff  <= loop_start_in;
         rate_ff        <= rate_in;
         pos_ff         <= pos_in;
         accum_ff       <= accum_in;
         cnt_ff         <= cnt_in;
         active_ff      <= active_in;
         stop_ff        <= stop_in;
         base_x_ff      <= base_x_in;
         base_y_ff      <= base_y_in;
         hflip_ff       <= hflip_in;
         vflip_ff       <= vflip_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // capture request, table write, registered table read
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         item_ff <= req_item;
      end
      if (cmd.exec && (kind_ff == REQ_WRITE)) begin
         mem[item_ff.entry_index] <= '{hold_time: item_ff.entry_time,
                                       cell_id:   item_ff.entry_cell,
                                       dx:        item_ff.entry_dx,
                                       dy:        item_ff.entry_dy};
      end
      if (cmd.rd_en) rd_data_ff <= mem[pos_in];
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.pad           <= '0;
         rsp_ff.is_stopped    <= stop_ff;
         rsp_ff.is_active     <= active_ff;
         rsp_ff.current_frame <= pos_ff;
         rsp_ff.shown_vflip   <= active_ff & vflip_ff;
         rsp_ff.shown_hflip   <= active_ff & hflip_ff;
         rsp_ff.shown_y       <= active_ff ? y_sum : '0;
         rsp_ff.shown_x       <= active_ff ? x_sum : '0;
         rsp_ff.shown_cell    <= active_ff ? rd_data_ff.cell_id : '0;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_item       = rsp_ff;
   assign stat.kind      = kind_ff;
   assign stat.active    = active_ff;
   assign stat.accum_pos = !accum_ff[ACC_W-1] && (accum_ff != '0);
   assign stat.step_wrap = wrap;
   assign stat.rsp_free  = rsp_free;

endmodule

// ===== rtl/sas_ctrl.sv =====
// Controller of the sprite animation sequencer: sequences request execution,
// frame steps, table reads and result hand-off. Depends on sas_pkg.
module sas_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sas_pkg::status_type stat,
   output sas_pkg::cmd_type    cmd
);
   import sas_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_STEP   = 3'd2;
   localparam logic [2:0] S_LOAD   = 3'd3;
   localparam logic [2:0] S_LOOK   = 3'd4;
   localparam logic [2:0] S_RESULT = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            case (stat.kind)
               REQ_TICK: begin
                  if (stat.active) begin
                     state_in = S_STEP;
                  end else begin
                     cmd.rd_en = 1'b1;
                     state_in  = S_RESULT;
                  end
               end
               REQ_START: begin
                  cmd.rd_en = 1'b1;
                  state_in  = S_LOAD;
               end
               REQ_WRITE: begin
                  state_in = S_LOOK;
               end
               default: begin
                  cmd.rd_en = 1'b1;
                  state_in  = S_RESULT;
               end
            endcase
         end
         // steps until the accumulator is positive again, reading the new entry on a frame change
         S_STEP: begin
            if (stat.accum_pos) begin
               cmd.rd_en = 1'b1;
               state_in  = S_RESULT;
            end else begin
               cmd.step = 1'b1;
               if (stat.step_wrap) begin
                  cmd.rd_en = 1'b1;
                  state_in  = S_LOAD;
               end
            end
         end
         // table data of the new frame is here: reload countdown
         S_LOAD: begin
            cmd.load_cnt = 1'b1;
            state_in     = (stat.kind == REQ_TICK) ? S_STEP : S_RESULT;
         end
         S_LOOK: begin
            cmd.rd_en = 1'b1;
            state_in  = S_RESULT;
         end
         // hold until the result register is free
         S_RESULT: begin
            if (stat.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== rtl/sprite_animation_sequencer.sv =====
// Sprite animation sequencer, top level. An accepted transaction goes through S_EXEC and then
// S_RESULT; a start passes through S_LOAD and a table write through S_LOOK between them, and an
// active tick loops in S_STEP, taking frame steps, and passes through S_LOAD on each frame
// change. S_RESULT holds until the result register is free; the next transaction is taken only
// once the controller is back in S_IDLE, after the result has been loaded.
// Synchronous reset clears the playback state, loads default configuration and empties the
// result register; the frame table is not cleared.
module sprite_animation_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // entry_index, entry_time, entry_cell, entry_dx, entry_dy, new_x, new_y,
   // new_hflip, new_vflip, zero fill
   input  logic [sas_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_type
   input  logic [sas_pkg::KIND_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // shown_cell, shown_x, shown_y, shown_hflip, shown_vflip, current_frame,
   // is_active, is_stopped, zero fill
   output logic [sas_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [sas_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [sas_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sas_pkg::*;

   cmd_type      cmd;
   status_type   stat;
   req_item_type req_item;
   rsp_item_type rsp_item;

   assign req_item  = req_item_type'(req_tdata);
   assign rsp_tdata = RSP_DATA_W'(rsp_item);

   sas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sas_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_kind   (req_tuser),
      .req_item   (req_item),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_item   (rsp_item),
      .cmd        (cmd),
      .stat       (stat)
   );

   // an inactive sequencer shows no cell, position or flip
   a_inactive_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_item.is_active |-> rsp_tdata[45:0] == 46'd0)
      else $error("inactive result carries display data");

   // stop can only be reached while playing
   a_stop_needs_active: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_item.is_stopped && !rsp_item.is_active))
      else $error("stopped flag set without an active animation");

   // one transaction at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction accepted while one is in flight");

   // the result register is loaded only when it is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_tvalid || rsp_tready)
      else $error("result overwritten before it was taken");

endmodule

// ===== sim/sprite_animation_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sprite_animation_sequencer: directed and random playback traffic
// with random stalls on both streams, checked against an in-bench playback model.
// Depends on sas_pkg and the sequencer RTL only.
module sprite_animation_sequencer_tb;
   import sas_pkg::*;

   localparam int CLK_HALF         = 6;
   localparam int ITEM_TARGET      = 850;
   localparam int SETTLE_CYCLES    = 16;
   localparam int TAIL_CYCLES      = 30;
   localparam int LONG_HOLD        = 300;
   localparam int HOLD_SPACING     = 350;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int REPORT_LIMIT     = 10;
   localparam logic [KIND_W-1:0] REQ_FIRST_UNUSED = 3'd5;

   // one frame of the animation as the model keeps it
   typedef struct {
      int                         hold_steps;
      logic [CELL_W-1:0]          cell_no;
      logic signed [COORD_W-1:0]  off_x;
      logic signed [COORD_W-1:0]  off_y;
   } frame_rec_type;

   // one pending stimulus step: a request transaction or a register write
   typedef struct {
      bit                    is_csr;
      logic [KIND_W-1:0]     kind;
      req_item_type          body;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] value;
   } seq_op_type;

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [KIND_W-1:0]       req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr   = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   sprite_animation_sequencer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Playback model: state, configuration and expected display results
   // ---------------------------------------------------------------------------------------
   frame_rec_type            anim_frames [MAX_FRAMES];
   logic [FRAME_W-1:0]       play_pos      = '0;
   int                       play_accum    = 0;
   int                       play_hold     = 0;
   bit                       play_active   = 1'b0;
   bit                       play_stopped  = 1'b0;
   logic signed [COORD_W-1:0] sprite_x     = '0;
   logic signed [COORD_W-1:0] sprite_y     = '0;
   bit                       sprite_hflip  = 1'b0;
   bit                       sprite_vflip  = 1'b0;
   bit                       cfg_loop      = 1'b0;
   logic [FCOUNT_W-1:0]      cfg_frames    = 7'd1;
   logic [FRAME_W-1:0]       cfg_loop_at   = '0;
   logic [RATE_W-1:0]        cfg_rate      = RATE_W'(RATE_UNIT);

   rsp_item_type             display_q [$];

   // rewind to frame 0; a start also arms the first frame's countdown
   task automatic restart_playback(bit run);
      play_pos     = '0;
      play_accum   = 0;
      play_stopped = 1'b0;
      cfg_rate     = RATE_W'(RATE_UNIT);
      play_active  = run;
      if (run)
         play_hold = anim_frames[0].hold_steps;
   endtask

   // count one frame step down and move on once the frame has been shown long enough
   task automatic step_frame();
      int span;
      span = (cfg_frames > MAX_FRAMES) ? MAX_FRAMES : int'(cfg_frames);
      play_hold--;
      if (play_hold <= 0) begin
         if (int'(play_pos) + 1 >= span) begin
            if (!cfg_loop)
               play_stopped = 1'b1;
            else
               play_pos = cfg_loop_at;
         end else begin
            play_pos = play_pos + 1'b1;
         end
         play_hold = anim_frames[play_pos].hold_steps;
      end
   endtask

   // spend the rate on the accumulator and take whole frame steps out of it
   task automatic run_tick();
      int rate;
      if (play_active) begin
         rate = play_stopped ? 0 : int'(cfg_rate);
         play_accum -= rate;
         while (play_accum <= 0) begin
            play_accum += RATE_UNIT;
            step_frame();
         end
      end
   endtask

   // apply one request transaction and queue the display state it leaves behind
   task automatic apply_request(logic [KIND_W-1:0] kind, req_item_type body);
      rsp_item_type  shown;
      frame_rec_type cur;
      int            sum_x;
      int            sum_y;
      case (kind)
         REQ_TICK:   run_tick();
         REQ_WRITE: begin
            anim_frames[body.entry_index].hold_steps = int'(body.entry_time);
            anim_frames[body.entry_index].cell_no    = body.entry_cell;
            anim_frames[body.entry_index].off_x      = body.entry_dx;
            anim_frames[body.entry_index].off_y      = body.entry_dy;
         end
         REQ_START:  restart_playback(1'b1);
         REQ_SETPOS: begin
            sprite_x     = body.new_x;
            sprite_y     = body.new_y;
            sprite_hflip = body.new_hflip;
            sprite_vflip = body.new_vflip;
         end
         REQ_CLEAR:  restart_playback(1'b0);
         default: ;
      endcase
      shown = '0;
      if (play_active) begin
         cur   = anim_frames[play_pos];
         sum_x = int'($signed(sprite_x)) + int'($signed(cur.off_x));
         sum_y = int'($signed(sprite_y)) + int'($signed(cur.off_y));
         shown.shown_cell  = cur.cell_no;
         shown.shown_x     = sum_x[POS_W-1:0];
         shown.shown_y     = sum_y[POS_W-1:0];
         shown.shown_hflip = sprite_hflip;
         shown.shown_vflip = sprite_vflip;
      end
      shown.current_frame = play_pos;
      shown.is_active     = play_active;
      shown.is_stopped    = play_stopped;
      display_q.push_back(shown);
   endtask

   task automatic apply_csr(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
      case (addr)
         CSR_PLAY_MODE:   cfg_loop    = value[0];
         CSR_FRAME_COUNT: cfg_frames  = value[FCOUNT_W-1:0];
         CSR_LOOP_START:  cfg_loop_at = value[FRAME_W-1:0];
         CSR_RATE:        cfg_rate    = value[RATE_W-1:0];
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------------------------
   seq_op_type          op_q [$];
   int                  total_ops     = 0;
   int                  done_ops      = 0;
   int                  known_items   = 0;
   bit                  entry_written [MAX_FRAMES];
   logic [FCOUNT_W-1:0] plan_frames   = 7'd1;
   logic [FRAME_W-1:0]  plan_loop_at  = '0;

   // every field but the pad random, so that unused fields toggle as well
   function automatic req_item_type noise_body();
      req_item_type b;
      b.pad         = '0;
      b.new_vflip   = 1'($urandom);
      b.new_hflip   = 1'($urandom);
      b.new_y       = COORD_W'($urandom);
      b.new_x       = COORD_W'($urandom);
      b.entry_dy    = COORD_W'($urandom);
      b.entry_dx    = COORD_W'($urandom);
      b.entry_cell  = CELL_W'($urandom);
      b.entry_time  = TIME_W'($urandom);
      b.entry_index = FRAME_W'($urandom);
      return b;
   endfunction

   // mostly short frames, now and then a long or huge one
   function automatic logic [TIME_W-1:0] rand_hold();
      case ($urandom_range(0, 79))
         0:             return '1;
         1:             return TIME_W'($urandom);
         2, 3, 4, 5, 6: return TIME_W'($urandom_range(6, 40));
         default:       return TIME_W'($urandom_range(0, 5));
      endcase
   endfunction

   task automatic push_item(logic [KIND_W-1:0] kind, req_item_type body);
      op_q.push_back('{is_csr: 1'b0, kind: kind, body: body, addr: '0, value: '0});
      if (kind <= REQ_CLEAR)
         known_items++;
   endtask

   task automatic push_kind(logic [KIND_W-1:0] kind);
      push_item(kind, noise_body());
   endtask

   task automatic push_write(int idx, logic [TIME_W-1:0] hold, logic [CELL_W-1:0] cell_no,
                             logic [COORD_W-1:0] dx, logic [COORD_W-1:0] dy);
      req_item_type b;
      b             = noise_body();
      b.entry_index = FRAME_W'(idx);
      b.entry_time  = hold;
      b.entry_cell  = cell_no;
      b.entry_dx    = dx;
      b.entry_dy    = dy;
      push_item(REQ_WRITE, b);
      entry_written[idx] = 1'b1;
   endtask

   task automatic push_random_write(int idx);
      push_write(idx, rand_hold(), CELL_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
   endtask

   task automatic push_setpos(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, bit hf, bit vf);
      req_item_type b;
      b           = noise_body();
      b.new_x     = x;
      b.new_y     = y;
      b.new_hflip = hf;
      b.new_vflip = vf;
      push_item(REQ_SETPOS, b);
   endtask

   task automatic push_csr(logic [CSR_ADDR_W-1:0] addr, int value);
      op_q.push_back('{is_csr: 1'b1, kind: REQ_TICK, body: '0, addr: addr,
                       value: CSR_DATA_W'(value)});
      if (addr == CSR_FRAME_COUNT)
         plan_frames = FCOUNT_W'(value);
      if (addr == CSR_LOOP_START)
         plan_loop_at = FRAME_W'(value);
   endtask

   function automatic int plan_span();
      return (plan_frames > MAX_FRAMES) ? MAX_FRAMES : int'(plan_frames);
   endfunction

   // load every entry playback can reach before anything reads it
   task automatic fill_reachable_entries();
      for (int i = 0; i < plan_span(); i++)
         if (!entry_written[i])
            push_random_write(i);
      if (!entry_written[plan_loop_at])
         push_random_write(plan_loop_at);
   endtask

   // new settings for the next phase, each register with even odds
   task automatic reconfigure();
      int v;
      if ($urandom_range(0, 1))
         push_csr(CSR_PLAY_MODE, $urandom_range(0, 1));
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = MAX_FRAMES;
            2:       v = $urandom_range(MAX_FRAMES + 1, 127);
            default: v = $urandom_range(1, 8);
         endcase
         push_csr(CSR_FRAME_COUNT, v);
      end
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 9))
            0:       v = MAX_FRAMES - 1;
            1, 2:    v = $urandom_range(0, MAX_FRAMES - 1);
            default: v = (plan_span() > 1) ? $urandom_range(0, plan_span() - 1) : 0;
         endcase
         push_csr(CSR_LOOP_START, v);
      end
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 7))
            0:       v = 0;
            1:       v = 400;
            2:       v = 511;
            default: v = $urandom_range(1, 400);
         endcase
         push_csr(CSR_RATE, v);
      end
   endtask

   // one burst of playback traffic, mostly ticks
   task automatic push_playback_burst();
      int pick;
      int idx;
      if ($urandom_range(0, 4) < 2)
         push_kind(REQ_START);
      repeat ($urandom_range(6, 30)) begin
         pick = $urandom_range(0, 99);
         if (pick < 68) begin
            push_kind(REQ_TICK);
         end else if (pick < 80) begin
            if ($urandom_range(0, 2) == 0 || plan_span() == 0)
               idx = $urandom_range(0, MAX_FRAMES - 1);
            else
               idx = $urandom_range(0, plan_span() - 1);
            push_random_write(idx);
         end else if (pick < 88) begin
            push_setpos(COORD_W'($urandom), COORD_W'($urandom), 1'($urandom), 1'($urandom));
         end else if (pick < 92) begin
            push_kind(REQ_START);
         end else if (pick < 95) begin
            push_kind(REQ_CLEAR);
         end else begin
            push_kind(REQ_FIRST_UNUSED + KIND_W'($urandom_range(0, 2)));
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Request driver and register writer
   // ---------------------------------------------------------------------------------------
   int  send_gap     = 0;
   bit  send_burst   = 1'b0;
   int  quiet_cycles = 0;

   always @(posedge clock) begin : drive_proc
      logic       fire;
      logic       nxt_valid;
      logic       nxt_we;
      seq_op_type op;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_we     <= 1'b0;
      end else begin
         fire      = req_tvalid && req_tready;
         nxt_valid = req_tvalid && !fire;
         nxt_we    = 1'b0;
         // model the accepted transaction, then draw the pause before the next one
         if (fire) begin
            apply_request(req_tuser, req_item_type'(req_tdata));
            done_ops++;
            if ($urandom_range(0, 39) == 0)
               send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 6);
         end
         if (display_q.size() == 0 && !req_tvalid)
            quiet_cycles++;
         else
            quiet_cycles = 0;
         if (!nxt_valid && op_q.size() > 0) begin
            if (op_q[0].is_csr) begin
               // write registers only once the block has drained
               if (quiet_cycles >= SETTLE_CYCLES) begin
                  op = op_q.pop_front();
                  apply_csr(op.addr, op.value);
                  done_ops++;
                  nxt_we = 1'b1;
                  csr_addr  <= op.addr;
                  csr_wdata <= op.value;
               end
            end else if (send_gap > 0) begin
               send_gap--;
            end else begin
               op = op_q.pop_front();
               nxt_valid = 1'b1;
               req_tuser <= op.kind;
               req_tdata <= REQ_DATA_W'(op.body);
            end
         end
         req_tvalid <= nxt_valid;
         csr_we     <= nxt_we;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result monitor and checker
   // ---------------------------------------------------------------------------------------
   int  mismatch_count = 0;
   int  rcv_count      = 0;
   int  recv_stall     = 0;
   bit  recv_burst     = 1'b0;
   int  next_hold_at   = 150;

   task automatic report(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s", $realtime, msg);
   endtask

   task automatic compare_field(string name, int idx, logic [POS_W-1:0] want,
                                logic [POS_W-1:0] got);
      if (want !== got)
         report($sformatf("result %0d %s: expected 0x%0h, got 0x%0h", idx, name, want, got));
   endtask

   always @(posedge clock) begin : watch_proc
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_item_type'(rsp_tdata);
            if (display_q.size() == 0) begin
               report($sformatf("result %0d arrived with nothing pending: 0x%0h",
                                rcv_count, rsp_tdata));
            end else begin
               want = display_q.pop_front();
               compare_field("shown_cell", rcv_count, POS_W'(want.shown_cell),
                             POS_W'(got.shown_cell));
               compare_field("shown_x", rcv_count, want.shown_x, got.shown_x);
               compare_field("shown_y", rcv_count, want.shown_y, got.shown_y);
               compare_field("shown_hflip", rcv_count, POS_W'(want.shown_hflip),
                             POS_W'(got.shown_hflip));
               compare_field("shown_vflip", rcv_count, POS_W'(want.shown_vflip),
                             POS_W'(got.shown_vflip));
               compare_field("current_frame", rcv_count, POS_W'(want.current_frame),
                             POS_W'(got.current_frame));
               compare_field("is_active", rcv_count, POS_W'(want.is_active),
                             POS_W'(got.is_active));
               compare_field("is_stopped", rcv_count, POS_W'(want.is_stopped),
                             POS_W'(got.is_stopped));
            end
            rcv_count++;
            if ($urandom_range(0, 39) == 0)
               recv_burst = !recv_burst;
            recv_stall = recv_burst ? 0 : $urandom_range(0, 6);
            // now and then hold off for long while work is still queued behind
            if (rcv_count >= next_hold_at && display_q.size() > 0) begin
               recv_stall   = LONG_HOLD;
               next_hold_at = rcv_count + HOLD_SPACING;
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // end the run if nothing moves for too long
   int idle_cycles = 0;

   always @(posedge clock) begin : watchdog_proc
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("sprite_animation_sequencer test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------------
   initial begin : sequence_proc
      foreach (entry_written[i])
         entry_written[i] = 1'b0;
      foreach (anim_frames[i])
         anim_frames[i] = '{hold_steps: 0, cell_no: '0, off_x: '0, off_y: '0};

      // inactive display, unknown kinds and the coordinate extremes
      push_write(0, 16'd1, 10'd1023, 16'sh7FFF, 16'sh8000);
      push_kind(REQ_TICK);
      push_kind(REQ_FIRST_UNUSED + 3'd2);
      push_setpos(16'sh7FFF, 16'sh8000, 1'b1, 1'b1);
      push_write(1, 16'd0, 10'd0, 16'sh8000, 16'sh7FFF);
      push_write(2, 16'd3, 10'd512, 16'sh0001, 16'shFFFF);
      // single-frame forward play runs into the stop, then clear
      push_kind(REQ_START);
      push_kind(REQ_TICK);
      push_kind(REQ_TICK);
      push_kind(REQ_CLEAR);
      push_kind(REQ_TICK);
      // looping over three frames, with a table rewrite while playing
      push_csr(CSR_PLAY_MODE, 1);
      push_csr(CSR_FRAME_COUNT, 3);
      push_csr(CSR_LOOP_START, 1);
      push_kind(REQ_START);
      repeat (3) push_kind(REQ_TICK);
      push_write(1, 16'd2, 10'd77, 16'sh0064, 16'shFF9C);
      push_kind(REQ_FIRST_UNUSED);
      push_kind(REQ_TICK);
      // a high rate, then zero rate right after a start
      push_csr(CSR_RATE, 400);
      repeat (2) push_kind(REQ_TICK);
      push_kind(REQ_START);
      push_csr(CSR_RATE, 0);
      repeat (2) push_kind(REQ_TICK);
      // zero frame count: every frame is the last one
      push_csr(CSR_FRAME_COUNT, 0);
      push_csr(CSR_LOOP_START, 2);
      push_csr(CSR_RATE, 250);
      repeat (2) push_kind(REQ_TICK);
      push_setpos(16'sh0000, 16'sh0000, 1'b0, 1'b0);

      // random phases of playback under changing settings
      known_items = 0;
      while (known_items < ITEM_TARGET) begin
         reconfigure();
         fill_reachable_entries();
         push_playback_burst();
      end
      total_ops = op_q.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // drain: all stimulus taken, every result back, then let the block settle
      while (done_ops < total_ops)
         @(negedge clock);
      while (display_q.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("sprite_animation_sequencer test passed");
      else
         $display("sprite_animation_sequencer test failed");
      $finish;
   end

endmodule
